@@ rtl/core/utf8_stream_decoder_defines.svh @@
// ----------------------------------------------------------------------------
// utf8_stream_decoder_defines
// Assertion macros shared by the decoder's checker.
// ----------------------------------------------------------------------------
`ifndef UTF8_STREAM_DECODER_DEFINES_SVH
`define UTF8_STREAM_DECODER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define U8D_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define U8D_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/u8d_pkg.sv @@
// ----------------------------------------------------------------------------
// u8d_pkg
// Types, constants and helpers for the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package u8d_pkg;

    localparam int unsigned CP_W  = 21;
    localparam int unsigned LEN_W = 3;
    localparam int unsigned CNT_W = 3;

    // sequence length codes
    localparam logic [LEN_W-1:0] LEN_NONE = 3'd0;
    localparam logic [LEN_W-1:0] LEN_1    = 3'd1;
    localparam logic [LEN_W-1:0] LEN_2    = 3'd2;
    localparam logic [LEN_W-1:0] LEN_3    = 3'd3;
    localparam logic [LEN_W-1:0] LEN_4    = 3'd4;

    localparam logic [CP_W-1:0] REPL_CP = 21'h00FFFD;
    localparam logic [CP_W-1:0] MAX_CP  = 21'h10FFFF;
    localparam logic [CP_W-1:0] SURR_LO = 21'h00D800;
    localparam logic [CP_W-1:0] SURR_HI = 21'h00DFFF;
    localparam logic [CP_W-1:0] MIN_2B  = 21'h000080;
    localparam logic [CP_W-1:0] MIN_3B  = 21'h000800;
    localparam logic [CP_W-1:0] MIN_4B  = 21'h010000;

    // pending multi-byte sequence
    typedef struct packed {
        logic [LEN_W-1:0] seq_len;
        logic [LEN_W-1:0] taken;
        logic [CP_W-1:0]  partial;
    } t_state;

    // results caused by one byte: cnt results, all U+FFFD/bad except a
    // good code point in the last slot when good is set
    typedef struct packed {
        logic [CNT_W-1:0] cnt;
        logic             good;
        logic [CP_W-1:0]  cp;
    } t_group;

    function automatic logic value_ok(input logic [LEN_W-1:0] len,
                                      input logic [CP_W-1:0] v);
        logic ok;
        ok = 1'b1;
        if (len == LEN_2 && v < MIN_2B) ok = 1'b0;
        if (len == LEN_3 && v < MIN_3B) ok = 1'b0;
        if (len == LEN_4 && v < MIN_4B) ok = 1'b0;
        if (v > MAX_CP) ok = 1'b0;
        if (v >= SURR_LO && v <= SURR_HI) ok = 1'b0;
        return ok;
    endfunction

endpackage

@@ rtl/core/u8d_in_if.sv @@
// ----------------------------------------------------------------------------
// u8d_in_if
// Byte channel into the decoder.
// ----------------------------------------------------------------------------
interface u8d_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_data;

    modport source (output valid, output in_byte, output end_of_data, input ready);
    modport sink   (input valid, input in_byte, input end_of_data, output ready);
endinterface

@@ rtl/core/u8d_out_if.sv @@
// ----------------------------------------------------------------------------
// u8d_out_if
// Code point channel out of the decoder.
// ----------------------------------------------------------------------------
interface u8d_out_if;
    logic                      valid;
    logic                      ready;
    logic [u8d_pkg::CP_W-1:0]  code_point;
    logic                      bad;
    logic                      last_of_run;

    modport source (output valid, output code_point, output bad, output last_of_run,
                    input ready);
    modport sink   (input valid, input code_point, input bad, input last_of_run,
                    output ready);
endinterface

@@ rtl/core/u8d_step.sv @@
// ----------------------------------------------------------------------------
// u8d_step
// Next-state and result-group logic for one input byte.
// ----------------------------------------------------------------------------
module u8d_step (
    input  logic [7:0]       i_byte,
    input  logic             i_eod,
    input  u8d_pkg::t_state  i_state,
    output u8d_pkg::t_state  o_state,
    output u8d_pkg::t_group  o_group
);

    logic                            pending;
    logic                            is_cont;
    logic [u8d_pkg::CP_W-1:0]        acc;
    logic [u8d_pkg::LEN_W-1:0]       taken_inc;
    logic [u8d_pkg::CNT_W-1:0]       errs;
    logic [u8d_pkg::LEN_W-1:0]       lead_len;
    logic [u8d_pkg::CP_W-1:0]        lead_bits;

    assign pending   = (i_state.seq_len != u8d_pkg::LEN_NONE);
    assign is_cont   = (i_byte[7:6] == 2'b10);
    assign acc       = {i_state.partial[u8d_pkg::CP_W-7:0], i_byte[5:0]};
    assign taken_inc = i_state.taken + 3'd1;

    // decode the lead byte
    always_comb begin
        lead_len  = u8d_pkg::LEN_NONE;
        lead_bits = '0;
        if (i_byte inside {[8'hC0:8'hDF]}) begin
            lead_len  = u8d_pkg::LEN_2;
            lead_bits = {16'd0, i_byte[4:0]};
        end else if (i_byte inside {[8'hE0:8'hEF]}) begin
            lead_len  = u8d_pkg::LEN_3;
            lead_bits = {17'd0, i_byte[3:0]};
        end else if (i_byte inside {[8'hF0:8'hF7]}) begin
            lead_len  = u8d_pkg::LEN_4;
            lead_bits = {18'd0, i_byte[2:0]};
        end
    end

    always_comb begin
        o_state = '0;
        o_group = '0;
        errs    = '0;
        if (pending && is_cont) begin
            if (taken_inc >= i_state.seq_len) begin
                if (u8d_pkg::value_ok(i_state.seq_len, acc)) begin
                    o_group.cnt  = 3'd1;
                    o_group.good = 1'b1;
                    o_group.cp   = acc;
                end else begin
                    o_group.cnt  = i_state.seq_len;
                end
            end else if (i_eod) begin
                o_group.cnt = taken_inc;
            end else begin
                o_state.seq_len = i_state.seq_len;
                o_state.taken   = taken_inc;
                o_state.partial = acc;
            end
        end else begin
            // flush a broken sequence, then take the byte as a new lead
            if (pending) errs = i_state.taken;
            if (!i_byte[7]) begin
                o_group.cnt  = errs + 3'd1;
                o_group.good = 1'b1;
                o_group.cp   = {13'd0, i_byte};
            end else if (lead_len == u8d_pkg::LEN_NONE || i_eod) begin
                o_group.cnt  = errs + 3'd1;
            end else begin
                o_group.cnt     = errs;
                o_state.seq_len = lead_len;
                o_state.taken   = u8d_pkg::LEN_1;
                o_state.partial = lead_bits;
            end
        end
    end

endmodule

@@ rtl/core/utf8_stream_decoder.sv @@
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// Output: the first result of a byte appears in the cycle after the byte's
// transaction; a byte that completes nothing yields no result.
// Throughput: one byte per cycle while each byte yields at most one result
// and the output is ready; a byte yielding N results (N up to 4) holds the
// input while the single result register drains them, one per ready cycle.
// Reset: synchronous, active low; clears the pending sequence and the result
// count.
// ----------------------------------------------------------------------------
module utf8_stream_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    u8d_in_if.sink      i_byte_ch,
    u8d_out_if.source   o_cp_ch
);

    // Decoder state: the pending sequence (length, bytes taken, bits so far).
    u8d_pkg::t_state            r_state;
    u8d_pkg::t_state            n_state;

    // Result register: a group of results for the last byte, drained one
    // per transaction. r_cnt counts the results still to deliver.
    logic [u8d_pkg::CNT_W-1:0]  r_cnt;
    logic                       r_good;
    logic [u8d_pkg::CP_W-1:0]   r_cp;

    u8d_pkg::t_group            step_grp;

    logic                       in_fire;
    logic                       out_fire;
    logic                       last_slot;

    u8d_step u_step (
        .i_byte  (i_byte_ch.in_byte),
        .i_eod   (i_byte_ch.end_of_data),
        .i_state (r_state),
        .o_state (n_state),
        .o_group (step_grp)
    );

    assign last_slot = (r_cnt == 3'd1);

    // Accept a new byte when the result register is empty or its final result
    // leaves in this same cycle: one byte per cycle while the output is ready.
    assign i_byte_ch.ready = (r_cnt == '0) || (last_slot && o_cp_ch.ready);
    assign in_fire         = i_byte_ch.valid && i_byte_ch.ready;

    assign o_cp_ch.valid       = (r_cnt != '0);
    assign out_fire            = o_cp_ch.valid && o_cp_ch.ready;
    // Only the last result of a group can be a good code point.
    assign o_cp_ch.bad         = !(last_slot && r_good);
    assign o_cp_ch.code_point  = (last_slot && r_good) ? r_cp : u8d_pkg::REPL_CP;
    assign o_cp_ch.last_of_run = last_slot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
            r_cnt   <= '0;
        end else begin
            if (in_fire) begin
                // advance the sequence and load the new group (may be empty)
                r_state <= n_state;
                r_cnt   <= step_grp.cnt;
            end else if (out_fire) begin
                r_cnt   <= r_cnt - 3'd1;
            end
        end
    end

    // payload of the group, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_good <= step_grp.good;
            r_cp   <= step_grp.cp;
        end
    end

endmodule

@@ rtl/core/u8d_checker.sv @@
// ----------------------------------------------------------------------------
// u8d_checker
// Port-level checks on the decoder's result channel.
// ----------------------------------------------------------------------------
`include "utf8_stream_decoder_defines.svh"

module u8d_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_out_valid,
    input logic                      i_out_ready,
    input logic [u8d_pkg::CP_W-1:0]  i_code_point,
    input logic                      i_bad,
    input logic                      i_last_of_run
);

    `U8D_ASSERT_NXT(a_hold_stalled, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_code_point) && $stable(i_bad) && $stable(i_last_of_run), "stalled result changed")
    `U8D_ASSERT_NXT(a_run_continues, i_clk, i_rst_n, i_out_valid && !i_last_of_run, i_out_valid, "run of results broken")
    `U8D_ASSERT_IMP(a_early_is_bad, i_clk, i_rst_n, i_out_valid && !i_last_of_run, i_bad && (i_code_point == u8d_pkg::REPL_CP), "good result before end of run")
    `U8D_ASSERT_IMP(a_good_is_scalar, i_clk, i_rst_n, i_out_valid && !i_bad, (i_code_point <= u8d_pkg::MAX_CP) && ((i_code_point < u8d_pkg::SURR_LO) || (i_code_point > u8d_pkg::SURR_HI)), "good result not a scalar value")

endmodule

bind utf8_stream_decoder u8d_checker u_u8d_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_cp_ch.valid),
    .i_out_ready   (o_cp_ch.ready),
    .i_code_point  (o_cp_ch.code_point),
    .i_bad         (o_cp_ch.bad),
    .i_last_of_run (o_cp_ch.last_of_run)
);

@@ tb/utf8_stream_decoder_checker.sv @@
// ----------------------------------------------------------------------------
// utf8_stream_decoder_checker
// Watches both channels of the decoder, predicts the code points that each
// accepted byte causes and compares every accepted result against them.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    u8d_in_if    i_byte_ch,
    u8d_out_if   i_cp_ch,
    output int   o_fail_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import u8d_pkg::*;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            bad;
        logic            last_of_run;
    } t_cp_result;

    t_cp_result       cp_expected[$];
    logic [LEN_W-1:0] seq_len;
    logic [LEN_W-1:0] taken;
    logic [CP_W-1:0]  partial;
    int               fail_count;

    function automatic logic code_point_legal(input logic [LEN_W-1:0] len,
                                              input logic [CP_W-1:0] v);
        if (len == LEN_2 && v < MIN_2B) return 1'b0;
        if (len == LEN_3 && v < MIN_3B) return 1'b0;
        if (len == LEN_4 && v < MIN_4B) return 1'b0;
        if (v > MAX_CP) return 1'b0;
        return !(v >= SURR_LO && v <= SURR_HI);
    endfunction

    task automatic report_mismatch(input string what, input logic [CP_W-1:0] got,
                                   input logic [CP_W-1:0] want);
        $display("%0t ns: %s mismatch, got 0x%0h, expected 0x%0h", $time, what, got, want);
        fail_count++;
    endtask

    task automatic drop_sequence();
        seq_len = LEN_NONE;
        taken   = '0;
        partial = '0;
    endtask

    task automatic push_result(input logic [CP_W-1:0] cp, input logic is_bad);
        cp_expected.push_back('{code_point: cp, bad: is_bad, last_of_run: 1'b0});
    endtask

    task automatic push_replacements(input logic [LEN_W-1:0] count);
        for (int unsigned k = 0; k < count; k++)
            push_result(REPL_CP, 1'b1);
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic eod);
        int unsigned      first_new;
        logic             consumed;
        logic [LEN_W-1:0] lead_len;
        logic [CP_W-1:0]  lead_bits;
        t_cp_result       tail;
        first_new = cp_expected.size();
        consumed  = 1'b0;
        lead_len  = LEN_NONE;
        lead_bits = '0;
        if (seq_len != LEN_NONE) begin
            if (b[7:6] == 2'b10) begin
                partial = {partial[CP_W-7:0], b[5:0]};
                taken   = taken + 1'b1;
                if (taken >= seq_len) begin
                    if (code_point_legal(seq_len, partial))
                        push_result(partial, 1'b0);
                    else
                        push_replacements(seq_len);
                    drop_sequence();
                end else if (eod) begin
                    push_replacements(taken);
                    drop_sequence();
                end
                consumed = 1'b1;
            end else begin
                // broken sequence: flush it, then treat the byte as a new lead
                push_replacements(taken);
                drop_sequence();
            end
        end
        if (!consumed) begin
            if (!b[7]) begin
                push_result({{(CP_W-8){1'b0}}, b}, 1'b0);
            end else begin
                if (b[7:5] == 3'b110) begin
                    lead_len  = LEN_2;
                    lead_bits = {{(CP_W-5){1'b0}}, b[4:0]};
                end else if (b[7:4] == 4'b1110) begin
                    lead_len  = LEN_3;
                    lead_bits = {{(CP_W-4){1'b0}}, b[3:0]};
                end else if (b[7:3] == 5'b11110) begin
                    lead_len  = LEN_4;
                    lead_bits = {{(CP_W-3){1'b0}}, b[2:0]};
                end
                if (lead_len == LEN_NONE || eod) begin
                    push_replacements(3'd1);
                end else begin
                    seq_len = lead_len;
                    taken   = 3'd1;
                    partial = lead_bits;
                end
            end
        end
        if (cp_expected.size() > first_new) begin
            tail = cp_expected.pop_back();
            tail.last_of_run = 1'b1;
            cp_expected.push_back(tail);
        end
    endtask

    task automatic check_result();
        t_cp_result want;
        if (cp_expected.size() == 0) begin
            report_mismatch("unrequested code_point", i_cp_ch.code_point, '0);
            return;
        end
        want = cp_expected.pop_front();
        if (i_cp_ch.code_point !== want.code_point)
            report_mismatch("code_point", i_cp_ch.code_point, want.code_point);
        if (i_cp_ch.bad !== want.bad)
            report_mismatch("bad", CP_W'(i_cp_ch.bad), CP_W'(want.bad));
        if (i_cp_ch.last_of_run !== want.last_of_run)
            report_mismatch("last_of_run", CP_W'(i_cp_ch.last_of_run),
                            CP_W'(want.last_of_run));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            drop_sequence();
            cp_expected.delete();
        end else begin
            // results at this edge stem from earlier bytes, so check first
            if (i_cp_ch.valid && i_cp_ch.ready)
                check_result();
            if (i_byte_ch.valid && i_byte_ch.ready)
                decode_byte(i_byte_ch.in_byte, i_byte_ch.end_of_data);
        end
        o_pending    = cp_expected.size();
        o_fail_count = fail_count;
    end

endmodule

@@ tb/utf8_stream_decoder_test.sv @@
// ----------------------------------------------------------------------------
// utf8_stream_decoder_test
// Drives byte streams into the UTF-8 decoder with random gaps and output
// stalls: a directed set of edge cases, then random well-formed, malformed
// and truncated sequences. The checker judges every result.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_test;
    timeunit 1ns;
    timeprecision 1ps;

    import u8d_pkg::*;

    localparam int unsigned RANDOM_BYTES = 100;
    localparam int unsigned STALL_LIMIT  = 2000;
    localparam int unsigned DRAIN_CYCLES = 8;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        sink_ready = 1'b0;
    logic        sink_calm  = 1'b0;
    logic        sender_calm;
    int unsigned stall_left = 0;
    int unsigned mode_left  = 0;
    int unsigned idle_cycles = 0;
    int          fail_count;
    int          pending_count;
    logic [7:0]  stream_bytes[$];
    logic        stream_last[$];

    u8d_in_if  byte_ch ();
    u8d_out_if cp_ch ();

    utf8_stream_decoder u_top (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_byte_ch (byte_ch),
        .o_cp_ch   (cp_ch)
    );

    utf8_stream_decoder_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte_ch    (byte_ch),
        .i_cp_ch      (cp_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    // 20 ns period
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    assign cp_ch.ready = sink_ready;

    // Mostly short idle stretches, now and then a long one.
    function automatic int unsigned random_gap();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(3, 1);
        return $urandom_range(30, 8);
    endfunction

    // Output side: stall at random, but each time mode_left runs out pick anew
    // between a calm mode (always ready) and a stalling mode.
    always @(negedge i_clk) begin
        if (mode_left == 0) begin
            sink_calm <= ($urandom_range(3) == 0);
            mode_left <= 64;
        end else begin
            mode_left <= mode_left - 1;
        end
        if (stall_left != 0) begin
            sink_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (sink_calm || $urandom_range(99) < 60) begin
            sink_ready <= 1'b1;
        end else begin
            sink_ready <= 1'b0;
            stall_left <= random_gap();
        end
    end

    // Watchdog: end the run when nothing moves on either channel for too long.
    always @(posedge i_clk) begin
        if ((byte_ch.valid && byte_ch.ready) || (cp_ch.valid && cp_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic add_byte(input logic [7:0] value, input logic last);
        stream_bytes.push_back(value);
        stream_last.push_back(last);
    endtask

    // Split cp over a len-byte encoding and queue the first keep bytes;
    // flag end of data on the last queued byte when last is set.
    task automatic add_encoded(input int len, input logic [CP_W-1:0] cp,
                               input int keep, input logic last);
        logic [7:0]      enc[4];
        logic [CP_W-1:0] rest;
        int              k;
        rest = cp;
        for (k = len - 1; k >= 1; k--) begin
            enc[k] = {2'b10, rest[5:0]};
            rest   = rest >> 6;
        end
        // lead prefix marks the length; rest holds the top payload bits
        case (len)
            2:       enc[0] = 8'hC0 | rest[7:0];
            3:       enc[0] = 8'hE0 | rest[7:0];
            4:       enc[0] = 8'hF0 | rest[7:0];
            default: enc[0] = rest[7:0];
        endcase
        for (k = 0; k < keep; k++)
            add_byte(enc[k], last && (k == keep - 1));
    endtask

    // Queue one random unit: ASCII, a legal sequence, a sequence with random
    // payload (overlong, surrogate, too large), a truncated one, or noise.
    task automatic add_random_unit();
        int unsigned     r;
        int              len;
        logic            last;
        logic [CP_W-1:0] cp;
        int unsigned     raw;
        r    = $urandom_range(99);
        len  = $urandom_range(4, 2);
        last = ($urandom_range(9) == 0);
        raw  = $urandom % (32'd1 << (5 * len + 1));
        cp   = raw[CP_W-1:0];
        if (r < 25) begin
            add_byte({1'b0, 7'($urandom)}, last);
        end else if (r < 60) begin
            case (len)
                2: cp = CP_W'($urandom_range(32'h7FF, 32'h80));
                3: begin
                    cp = CP_W'($urandom_range(32'hFFFF, 32'h800));
                    if (cp >= SURR_LO && cp <= SURR_HI)
                        cp = cp - MIN_3B;
                end
                default: cp = CP_W'($urandom_range(32'h10FFFF, 32'h10000));
            endcase
            add_encoded(len, cp, len, last);
        end else if (r < 78) begin
            add_encoded(len, cp, len, last);
        end else if (r < 90) begin
            add_encoded(len, cp, $urandom_range(len - 1, 1), 1'($urandom_range(1)));
        end else begin
            add_byte(8'($urandom), last);
        end
    endtask

    // Present one byte at a falling edge and hold it until the decoder
    // takes the transaction.
    task automatic send_byte(input logic [7:0] value, input logic last);
        int unsigned gap;
        gap = sender_calm ? 0 : random_gap();
        repeat (gap) begin
            @(negedge i_clk);
            byte_ch.valid <= 1'b0;
        end
        @(negedge i_clk);
        byte_ch.valid       <= 1'b1;
        byte_ch.in_byte     <= value;
        byte_ch.end_of_data <= last;
        @(posedge i_clk);
        while (!byte_ch.ready)
            @(posedge i_clk);
    endtask

    // Hold the input idle until every predicted result has come out.
    task automatic wait_drained();
        @(negedge i_clk);
        byte_ch.valid <= 1'b0;
        while (pending_count != 0)
            @(negedge i_clk);
    endtask

    initial begin
        int unsigned directed_end;
        byte_ch.valid       <= 1'b0;
        byte_ch.in_byte     <= 8'h00;
        byte_ch.end_of_data <= 1'b0;
        sender_calm = 1'b0;

        // Directed part: field extremes and each malformed case.
        add_byte(8'h00, 1'b0);
        add_byte(8'h7F, 1'b0);
        add_byte(8'h80, 1'b0);                  // stray continuation
        add_byte(8'hFF, 1'b0);                  // invalid lead
        add_encoded(2, 21'h0000E9, 2, 1'b0);
        add_encoded(4, MAX_CP, 4, 1'b0);        // highest legal code point
        add_encoded(4, 21'h110000, 4, 1'b0);    // beyond the code space
        add_encoded(2, 21'h000000, 2, 1'b0);    // overlong
        add_encoded(3, SURR_LO, 3, 1'b0);       // surrogate
        add_encoded(3, REPL_CP, 3, 1'b0);       // legal U+FFFD, not bad
        add_encoded(4, 21'h01F600, 3, 1'b0);    // three bytes taken ...
        add_byte(8'hFF, 1'b0);                  // ... broken by a bad lead
        add_encoded(3, 21'h0020AC, 2, 1'b1);    // end of data mid sequence
        add_byte(8'hC3, 1'b1);                  // end of data on a lead
        directed_end = stream_bytes.size();

        while (stream_bytes.size() < directed_end + RANDOM_BYTES)
            add_random_unit();

        // Release reset at a falling edge.
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (stream_bytes[idx]) begin
            // Let everything drain once after the directed part and once
            // halfway through the random part.
            if (idx == directed_end || idx == directed_end + RANDOM_BYTES / 2)
                wait_drained();
            // Flip between gapless stretches and gappy ones.
            if (idx % 20 == 0)
                sender_calm = ($urandom_range(3) == 0);
            send_byte(stream_bytes[idx], stream_last[idx]);
        end

        @(negedge i_clk);
        byte_ch.valid <= 1'b0;
        while (pending_count != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
